// ----- src/sdia_pkg.sv -----
// Shared types, constants and helpers for the signed integer to decimal text converter.
`timescale 1ns / 1ps
`default_nettype none

package sdia_pkg;

  localparam int unsigned NBits    = 32;
  localparam int unsigned NDigits  = 10;
  localparam int unsigned BcdBits  = 4 * NDigits;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrBits = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntBits = $clog2(QDepth + 1);
  localparam int unsigned StepBits = $clog2(NBits);
  localparam int unsigned DcntBits = $clog2(NDigits + 1);

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  // Classified request: sign flag and unsigned magnitude.
  typedef struct packed {
    logic             neg;
    logic [NBits-1:0] mag;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  // Add 3 to every BCD digit of 5 or more ahead of a shift.
  function automatic logic [BcdBits-1:0] bcd_adjust(input logic [BcdBits-1:0] bcd);
    logic [BcdBits-1:0] res;
    logic [3:0]         dig;
    res = bcd;
    for (int k = 0; k < NDigits; k++) begin
      dig = bcd[4*k +: 4];
      if (dig >= 4'd5) begin
        res[4*k +: 4] = dig + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/sdia_front.sv -----
// Front end: takes requests, splits them into sign and magnitude.
`timescale 1ns / 1ps
`default_nettype none

module sdia_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [31:0]          value,
  output logic                      q_valid,
  input  wire logic                 q_stall,
  output sdia_pkg::item_t           q_item
);
  import sdia_pkg::*;

  logic  fr_valid;
  logic  fr_valid_next;
  item_t fr_item;
  logic  accept;

  assign in_stall = fr_valid & q_stall;
  assign accept   = in_valid & ~in_stall;

  assign fr_valid_next = accept | (fr_valid & q_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else begin
      fr_valid <= fr_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item.neg <= value[NBits-1];
      fr_item.mag <= value[NBits-1] ? (~value + 32'd1) : value;
    end
  end

  assign q_valid = fr_valid;
  assign q_item  = fr_item;

endmodule

`default_nettype wire

// ----- src/sdia_queue.sv -----
// Short request queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none

module sdia_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push_valid,
  output logic                      push_stall,
  input  wire sdia_pkg::item_t      push_item,
  output logic                      pop_valid,
  input  wire logic                 pop_take,
  output sdia_pkg::item_t           pop_item
);
  import sdia_pkg::*;

  item_t                mem [QDepth];
  logic [QPtrBits-1:0]  wr_ptr;
  logic [QPtrBits-1:0]  rd_ptr;
  logic [QCntBits-1:0]  count;
  logic                 push;
  logic                 pop;

  assign push_stall = (count == QCntBits'(QDepth));
  assign pop_valid  = (count != '0);
  assign push       = push_valid & ~push_stall;
  assign pop        = pop_take & pop_valid;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrBits'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrBits'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/sdia_back.sv -----
// Back end: binary to BCD by shift-add-3, then emits characters most significant first.
`timescale 1ns / 1ps
`default_nettype none

module sdia_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  output logic                      q_take,
  input  wire sdia_pkg::item_t      q_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                text_char,
  output logic                      last_char
);
  import sdia_pkg::*;

  state_t              state;
  state_t              state_next;
  logic                neg;
  logic [NBits-1:0]    sh;
  logic [BcdBits-1:0]  bcd;
  logic [BcdBits-1:0]  bcd_adj;
  logic [StepBits-1:0] step;
  logic [DcntBits-1:0] dcnt;
  logic [3:0]          top;
  logic                top_zero;
  logic                slot_free;
  logic                conv_step;
  logic                skip_step;
  logic                emit_sign;
  logic                emit_digit;
  logic                last_step;

  assign bcd_adj   = bcd_adjust(bcd);
  assign top       = bcd[BcdBits-1 -: 4];
  assign top_zero  = (top == 4'd0) && (dcnt > DcntBits'(1));
  assign slot_free = ~out_valid | ~out_stall;
  assign last_step = (step == StepBits'(NBits - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (q_valid) state_next = ST_CONV;
      ST_CONV:   if (last_step) state_next = ST_SKIP;
      ST_SKIP:   if (!top_zero) state_next = neg ? ST_SIGN : ST_DIGITS;
      ST_SIGN:   if (slot_free) state_next = ST_DIGITS;
      ST_DIGITS: if (slot_free && dcnt == DcntBits'(1)) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_take     = 1'b0;
    conv_step  = 1'b0;
    skip_step  = 1'b0;
    emit_sign  = 1'b0;
    emit_digit = 1'b0;
    unique case (state)
      ST_IDLE:   q_take     = q_valid;
      ST_CONV:   conv_step  = 1'b1;
      ST_SKIP:   skip_step  = top_zero;
      ST_SIGN:   emit_sign  = slot_free;
      ST_DIGITS: emit_digit = slot_free;
      default:   q_take     = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_sign || emit_digit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      neg  <= q_item.neg;
      sh   <= q_item.mag;
      bcd  <= '0;
      step <= '0;
      dcnt <= DcntBits'(NDigits);
    end
    if (conv_step) begin
      bcd  <= {bcd_adj[BcdBits-2:0], sh[NBits-1]};
      sh   <= {sh[NBits-2:0], 1'b0};
      step <= step + 1'b1;
    end
    if (skip_step || emit_digit) begin
      bcd  <= {bcd[BcdBits-5:0], 4'd0};
      dcnt <= dcnt - 1'b1;
    end
    if (emit_digit) begin
      text_char <= CharZero + {4'd0, top};
      last_char <= (dcnt == DcntBits'(1));
    end
    if (emit_sign) begin
      text_char <= CharMinus;
      last_char <= 1'b0;
    end
  end

  a_skip_dcnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SKIP || state == ST_DIGITS) |-> (dcnt != '0))
    else $error("digit count ran out");

  a_sign_neg: assert property (@(posedge clk) disable iff (rst)
    emit_sign |-> neg)
    else $error("minus sign on a non-negative value");

  a_take_conv: assert property (@(posedge clk) disable iff (rst)
    q_take |=> (state == ST_CONV && step == '0))
    else $error("conversion did not start after a pop");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (text_char == CharMinus ||
                   (text_char >= CharZero && text_char <= CharZero + 8'd9)))
    else $error("character out of range");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && text_char == CharMinus) |-> !last_char)
    else $error("minus sign flagged as last");

endmodule

`default_nettype wire

// ----- src/signed_int_to_decimal_ascii.sv -----
// Top level: signed 32-bit integer to decimal ASCII text, one character per output request.
//
//   channel  dir  handshake            payload
//   input    in   in_valid / in_stall  value[31:0] (signed)
//   output   out  out_valid/ out_stall text_char[7:0], last_char
//
// Per value the back end pops it, runs 32 shift-add-3 steps to build ten BCD
// digits, skips leading zeros, then emits the characters one at a time (up to 11);
// it takes no new value until the last character of the current one has gone.
// Front end and a 2-entry queue accept further values while the back end works.
// Synchronous active-high reset clears valid flags, queue pointers and count, and back-end state; no clearing pass.
// An output stall holds the character; a full queue and full front end stall input.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       text_char,
  output logic             last_char
);
  import sdia_pkg::*;

  // front end -> queue
  logic  fq_valid;
  logic  fq_stall;
  item_t fq_item;

  // queue -> back end
  logic  qb_valid;
  logic  qb_take;
  item_t qb_item;

  // classify: sign flag plus unsigned magnitude (most negative value maps to 2^31)
  sdia_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .value    (value),
    .q_valid  (fq_valid),
    .q_stall  (fq_stall),
    .q_item   (fq_item)
  );

  // decouples intake from the long conversion in the back end
  sdia_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_stall (fq_stall),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_take   (qb_take),
    .pop_item   (qb_item)
  );

  // BCD conversion and character emission with a registered output stage
  sdia_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (qb_valid),
    .q_take    (qb_take),
    .q_item    (qb_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .text_char (text_char),
    .last_char (last_char)
  );

endmodule

`default_nettype wire
